### design/bracket_balance_checker_unit_assert.svh
// assertion macros for the bracket balance checker
`ifndef BRACKET_BALANCE_CHECKER_UNIT_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbc assertion failed");

// next-cycle implication, checked outside reset
`define BBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbc assertion failed");

`endif

### design/bbc_pkg.sv
// types and constants shared by the bracket balance checker
package bbc_pkg;

  localparam int NEST_DEPTH = 64;
  localparam int COUNT_W    = $clog2(NEST_DEPTH + 1);
  localparam int ADDR_W     = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int LEVEL_W    = 7;

  typedef logic [7:0]         char_t;
  typedef logic [1:0]         kind_t;
  typedef logic [1:0]         status_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [LEVEL_W-1:0] level_t;

  // stack entry kinds
  localparam kind_t KIND_PAREN = 2'd0;
  localparam kind_t KIND_BRACE = 2'd1;
  localparam kind_t KIND_BRACK = 2'd2;
  localparam kind_t KIND_QUOTE = 2'd3;

  // status and error codes
  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_BALANCED   = 2'd1;
  localparam status_t ST_UNBALANCED = 2'd2;
  localparam status_t ST_OVERFLOW   = 2'd3;

  // characters of interest
  localparam char_t CH_LPAREN = 8'h28;
  localparam char_t CH_RPAREN = 8'h29;
  localparam char_t CH_LBRACE = 8'h7B;
  localparam char_t CH_RBRACE = 8'h7D;
  localparam char_t CH_LBRACK = 8'h5B;
  localparam char_t CH_RBRACK = 8'h5D;
  localparam char_t CH_QUOTE  = 8'h27;

  // stack update for one item
  typedef struct packed {
    logic    push;
    logic    pop;
    kind_t   kind;
    count_t  count_next;
    status_t err_next;
  } stack_op_t;

  // stack state seen by the step logic
  typedef struct packed {
    kind_t   top;
    count_t  count;
    status_t err;
  } stack_state_t;

endpackage

### design/bbc_in_if.sv
// input channel: one text character per item
interface bbc_in_if;
  import bbc_pkg::*;

  logic  valid;
  logic  ready;
  char_t text_char;
  logic  last;

  modport source (output valid, output text_char, output last, input ready);
  modport sink   (input valid, input text_char, input last, output ready);
endinterface

### design/bbc_out_if.sv
// output channel: status and nesting level per item
interface bbc_out_if;
  import bbc_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  level_t  nesting_level;

  modport source (output valid, output status, output nesting_level, input ready);
  modport sink   (input valid, input status, input nesting_level, output ready);
endinterface

### design/bracket_balance_checker_unit.sv
// top level of the bracket balance checker
//
//   channel  dir  payload                  handshake
//   text     in   text_char[7:0], last     valid/ready
//   result   out  status[1:0], level[6:0]  valid/ready
//
// one item per cycle while results are taken; an accepted item passes the input
// register, then step logic into the result register, before its result is valid.
// the stack top and the entry below it sit in flip-flops, so each item needs
// one memory write or one registered memory read at most.
// synchronous reset empties the stack and clears the error; no clearing pass.
// a stalled result holds while the input register keeps taking one more item.
module bracket_balance_checker_unit (
  input  logic      clk,
  input  logic      rst,
  bbc_in_if.sink    text,
  bbc_out_if.source result
);
  import bbc_pkg::*;
  `include "bracket_balance_checker_unit_assert.svh"

  logic         s1_valid;
  char_t        s1_char;
  logic         s1_last;
  logic         advance;
  logic         out_valid;
  status_t      out_status;
  level_t       out_level;
  stack_op_t    op;
  stack_state_t st;
  status_t      step_status;
  level_t       step_level;

  assign advance    = s1_valid && (!out_valid || result.ready);
  assign text.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      s1_char <= text.text_char;
      s1_last <= text.last;
    end
  end

  bbc_step u_step (
    .text_char     (s1_char),
    .last          (s1_last),
    .st            (st),
    .op            (op),
    .status        (step_status),
    .nesting_level (step_level)
  );

  bbc_stack u_stack (
    .clk (clk),
    .rst (rst),
    .en  (advance),
    .op  (op),
    .st  (st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= step_status;
      out_level  <= step_level;
    end
  end

  assign result.valid         = out_valid;
  assign result.status        = out_status;
  assign result.nesting_level = out_level;

  `BBC_ASSERT_NOW(a_count_range, 1'b1, st.count <= COUNT_W'(NEST_DEPTH))
  `BBC_ASSERT_NEXT(a_last_clears, advance && s1_last, st.count == '0 && st.err == ST_OK)
  `BBC_ASSERT_NEXT(a_err_sticky, advance && !s1_last && st.err != ST_OK, st.err == $past(st.err) && st.count == $past(st.count))
  `BBC_ASSERT_NEXT(a_no_step_when_held, !advance, $stable(st.count) && $stable(st.err))
endmodule

### design/bbc_step.sv
// per-character decode and next-state logic
module bbc_step (
  input  bbc_pkg::char_t       text_char,
  input  logic                 last,
  input  bbc_pkg::stack_state_t st,
  output bbc_pkg::stack_op_t   op,
  output bbc_pkg::status_t     status,
  output bbc_pkg::level_t      nesting_level
);
  import bbc_pkg::*;

  logic    top_quote;
  logic    is_open;
  logic    is_close;
  kind_t   open_kind;
  kind_t   close_kind;
  logic    want_push;
  kind_t   want_kind;
  logic    do_pop;
  logic    full;
  logic    set_unbal;
  count_t  count_after;
  status_t err_after;

  always_comb begin
    is_open   = 1'b1;
    open_kind = KIND_PAREN;
    case (text_char)
      CH_LPAREN: open_kind = KIND_PAREN;
      CH_LBRACE: open_kind = KIND_BRACE;
      CH_LBRACK: open_kind = KIND_BRACK;
      default:   is_open = 1'b0;
    endcase
    is_close   = 1'b1;
    close_kind = KIND_PAREN;
    case (text_char)
      CH_RPAREN: close_kind = KIND_PAREN;
      CH_RBRACE: close_kind = KIND_BRACE;
      CH_RBRACK: close_kind = KIND_BRACK;
      default:   is_close = 1'b0;
    endcase
  end

  assign top_quote = (st.count != '0) && (st.top == KIND_QUOTE);
  assign full      = (st.count >= COUNT_W'(NEST_DEPTH));

  always_comb begin
    want_push = 1'b0;
    want_kind = KIND_QUOTE;
    do_pop    = 1'b0;
    set_unbal = 1'b0;
    // errors freeze the stack until the last character
    if (st.err == ST_OK) begin
      if (text_char == CH_QUOTE) begin
        if (top_quote) do_pop = 1'b1;
        else want_push = 1'b1;
      end else if (!top_quote) begin
        if (is_open) begin
          want_push = 1'b1;
          want_kind = open_kind;
        end else if (is_close) begin
          if ((st.count != '0) && (st.top == close_kind)) do_pop = 1'b1;
          else set_unbal = 1'b1;
        end
      end
    end
  end

  always_comb begin
    count_after = st.count;
    err_after   = st.err;
    if (want_push && full) err_after = ST_OVERFLOW;
    else if (want_push) count_after = st.count + COUNT_W'(1);
    else if (do_pop) count_after = st.count - COUNT_W'(1);
    else if (set_unbal) err_after = ST_UNBALANCED;

    if (!last) status = err_after;
    else if (err_after != ST_OK) status = err_after;
    else if (count_after != '0) status = ST_UNBALANCED;
    else status = ST_BALANCED;

    nesting_level = LEVEL_W'(count_after);

    op.push       = want_push && !full;
    op.pop        = do_pop;
    op.kind       = want_kind;
    op.count_next = last ? '0 : count_after;
    op.err_next   = last ? ST_OK : err_after;
  end
endmodule

### design/bbc_stack.sv
// bracket stack: top and next-below in registers, deeper entries in memory
module bbc_stack (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  bbc_pkg::stack_op_t    op,
  output bbc_pkg::stack_state_t st
);
  import bbc_pkg::*;

  kind_t   mem [NEST_DEPTH];
  kind_t   top;
  kind_t   second;
  count_t  count;
  status_t err;
  addr_t   wr_addr;
  addr_t   rd_addr;

  // old top goes to memory on push; entry below new top is fetched on pop
  assign wr_addr = ADDR_W'(count - COUNT_W'(1));
  assign rd_addr = ADDR_W'(op.count_next - COUNT_W'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      err   <= ST_OK;
    end else if (en) begin
      count <= op.count_next;
      err   <= op.err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (op.push) begin
        top    <= op.kind;
        second <= top;
        if (count != '0) mem[wr_addr] <= top;
      end else if (op.pop) begin
        top    <= second;
        second <= mem[rd_addr];
      end
    end
  end

  assign st.top   = top;
  assign st.count = count;
  assign st.err   = err;
endmodule

### tb/bbc_checker.sv
// checker for the bracket balance checker: predicts each result and compares it
module bbc_checker
  import bbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_ready,
  input  char_t   in_char,
  input  logic    in_last,
  input  logic    out_valid,
  input  logic    out_ready,
  input  status_t out_status,
  input  level_t  out_level,
  output int      fail_count,
  output int      pending,
  output int      results_seen,
  output int      texts_balanced,
  output int      texts_unbalanced,
  output int      texts_overflowed,
  output int      deepest_level
);

  typedef struct packed {
    logic    last;
    status_t status;
    level_t  level;
  } verdict_t;

  verdict_t    expected_verdicts[$];
  kind_t       open_kinds [NEST_DEPTH];
  int unsigned stack_depth;
  status_t     err_code;

  int n_fail;
  int n_results;
  int n_balanced;
  int n_unbalanced;
  int n_overflow;
  int max_level;

  function automatic logic top_is(kind_t k);
    return (stack_depth != 0) && (open_kinds[stack_depth - 1] == k);
  endfunction

  function automatic void push_open(kind_t k);
    if (stack_depth >= NEST_DEPTH) begin
      err_code = ST_OVERFLOW;
    end else begin
      open_kinds[stack_depth] = k;
      stack_depth++;
    end
  endfunction

  function automatic void close_with(kind_t k);
    if (top_is(k)) begin
      stack_depth--;
    end else begin
      err_code = ST_UNBALANCED;
    end
  endfunction

  function automatic void apply_char(char_t c);
    if (c == CH_QUOTE) begin
      if (top_is(KIND_QUOTE)) stack_depth--;
      else push_open(KIND_QUOTE);
    end else if (!top_is(KIND_QUOTE)) begin
      // brackets only count outside quotes
      case (c)
        CH_LPAREN: push_open(KIND_PAREN);
        CH_LBRACE: push_open(KIND_BRACE);
        CH_LBRACK: push_open(KIND_BRACK);
        CH_RPAREN: close_with(KIND_PAREN);
        CH_RBRACE: close_with(KIND_BRACE);
        CH_RBRACK: close_with(KIND_BRACK);
        default: ;
      endcase
    end
  endfunction

  function automatic verdict_t predict_char(char_t c, logic is_last);
    verdict_t v;
    // once an error is set the stack stays frozen until the last character
    if (err_code == ST_OK) apply_char(c);
    v.last = is_last;
    if (!is_last) v.status = err_code;
    else if (err_code != ST_OK) v.status = err_code;
    else if (stack_depth != 0) v.status = ST_UNBALANCED;
    else v.status = ST_BALANCED;
    v.level = level_t'(stack_depth);
    if (is_last) begin
      stack_depth = 0;
      err_code    = ST_OK;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      expected_verdicts.delete();
      stack_depth = 0;
      err_code    = ST_OK;
    end else begin
      if (in_valid && in_ready) begin
        expected_verdicts.push_back(predict_char(in_char, in_last));
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_verdicts.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected result status %0d level %0d, no item outstanding",
                   $time, out_status, out_level);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_status !== want.status) begin
            n_fail++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_status);
          end
          if (out_level !== want.level) begin
            n_fail++;
            $display("%0t: nesting level mismatch, expected %0d, actual %0d",
                     $time, want.level, out_level);
          end
          if (want.last) begin
            if (want.status == ST_BALANCED) n_balanced++;
            else if (want.status == ST_OVERFLOW) n_overflow++;
            else n_unbalanced++;
          end
          if (int'(want.level) > max_level) max_level = int'(want.level);
        end
      end
    end
    fail_count       <= n_fail;
    pending          <= expected_verdicts.size();
    results_seen     <= n_results;
    texts_balanced   <= n_balanced;
    texts_unbalanced <= n_unbalanced;
    texts_overflowed <= n_overflow;
    deepest_level    <= max_level;
  end

endmodule

### tb/tb_top.sv
// testbench top: drives text streams into the bracket balance checker and gives the verdict
module tb_top;
  import bbc_pkg::*;

  logic clk;
  logic rst;

  bbc_in_if  text_if ();
  bbc_out_if result_if ();

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int          items_sent    = 0;

  int fail_count;
  int pending;
  int results_seen;
  int texts_balanced;
  int texts_unbalanced;
  int texts_overflowed;
  int deepest_level;

  bracket_balance_checker_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .text   (text_if),
    .result (result_if)
  );

  bbc_checker u_check (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (text_if.valid),
    .in_ready         (text_if.ready),
    .in_char          (text_if.text_char),
    .in_last          (text_if.last),
    .out_valid        (result_if.valid),
    .out_ready        (result_if.ready),
    .out_status       (result_if.status),
    .out_level        (result_if.nesting_level),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_seen     (results_seen),
    .texts_balanced   (texts_balanced),
    .texts_unbalanced (texts_unbalanced),
    .texts_overflowed (texts_overflowed),
    .deepest_level    (deepest_level)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("FAIL bracket_balance_checker_unit");
    $finish;
  end

  initial result_if.ready = 1'b0;
  always @(negedge clk) begin
    result_if.ready = ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic char_t opener_char(kind_t k);
    case (k)
      KIND_PAREN: return CH_LPAREN;
      KIND_BRACE: return CH_LBRACE;
      KIND_BRACK: return CH_LBRACK;
      default:    return CH_QUOTE;
    endcase
  endfunction

  function automatic char_t closer_char(kind_t k);
    case (k)
      KIND_PAREN: return CH_RPAREN;
      KIND_BRACE: return CH_RBRACE;
      KIND_BRACK: return CH_RBRACK;
      default:    return CH_QUOTE;
    endcase
  endfunction

  task automatic send_char(input char_t c, input logic is_last);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 40) gap++;
    @(negedge clk);
    if (gap != 0) begin
      text_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_if.valid     = 1'b1;
    text_if.text_char = c;
    text_if.last      = is_last;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input char_t chars[$]);
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  // mostly well-nested text with noise, stray closers and quoted stretches
  task automatic gen_text(output char_t chars[$], input int unsigned len,
                          input int unsigned open_pct, input bit close_out);
    kind_t       shadow[$];
    kind_t       k;
    int unsigned r;
    chars = {};
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (shadow.size() != 0 && shadow[$] == KIND_QUOTE) begin
        if (r < 30) begin
          chars.push_back(CH_QUOTE);
          void'(shadow.pop_back());
        end else begin
          chars.push_back(char_t'($urandom_range(0, 255)));
        end
      end else if (r < open_pct) begin
        k = kind_t'($urandom_range(0, 3));
        chars.push_back(opener_char(k));
        shadow.push_back(k);
      end else if (r < open_pct + 25 && shadow.size() != 0) begin
        chars.push_back(closer_char(shadow.pop_back()));
      end else if (r < open_pct + 28) begin
        chars.push_back(closer_char(kind_t'($urandom_range(0, 2))));
      end else begin
        chars.push_back(char_t'($urandom_range(0, 255)));
      end
    end
    if (close_out) begin
      while (shadow.size() != 0) chars.push_back(closer_char(shadow.pop_back()));
    end
    if (chars.size() == 0) chars.push_back(char_t'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    text_if.valid = 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int n_items);
    char_t chars[$];
    int    target;
    send_idle_pct = idle;
    stall_pct     = stall;
    target        = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(0, 11) == 0) gen_text(chars, $urandom_range(60, 100), 80,
                                               $urandom_range(0, 1) != 0);
      else gen_text(chars, $urandom_range(1, 24), 35, $urandom_range(0, 9) != 0);
      send_text(chars);
    end
    // hold the sender until every result is back
    wait_drained();
  endtask

  initial begin
    char_t chars[$];
    int    waited;
    rst               = 1'b1;
    text_if.valid     = 1'b0;
    text_if.text_char = '0;
    text_if.last      = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // extremes of the byte around a matched pair
    send_char(8'h00, 1'b0);
    send_char(CH_LPAREN, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_RPAREN, 1'b1);
    // brackets inside quotes are ignored
    send_char(CH_LBRACE, 1'b0);
    send_char(CH_QUOTE, 1'b0);
    send_char(CH_RBRACK, 1'b0);
    send_char(CH_LPAREN, 1'b0);
    send_char(CH_QUOTE, 1'b0);
    send_char(CH_RBRACE, 1'b1);
    // wrong closer, then later characters are frozen out
    send_char(CH_LPAREN, 1'b0);
    send_char(CH_RBRACK, 1'b0);
    send_char(CH_LBRACK, 1'b0);
    send_char(CH_RPAREN, 1'b1);
    // closer on an empty stack
    send_char(CH_RBRACE, 1'b1);
    // openers still on the stack at the last character
    send_char(CH_LBRACK, 1'b0);
    send_char(CH_QUOTE, 1'b1);
    send_char(CH_QUOTE, 1'b1);
    // closer hidden by a quote
    send_char(CH_QUOTE, 1'b0);
    send_char(CH_RPAREN, 1'b0);
    send_char(CH_QUOTE, 1'b1);
    // text of one plain byte
    send_char(8'h80, 1'b1);
    wait_drained();

    // full stack without overflow, then one push past the top
    chars = {};
    for (int i = 0; i < NEST_DEPTH; i++) chars.push_back(opener_char(kind_t'($urandom_range(0, 2))));
    for (int i = NEST_DEPTH - 1; i >= 0; i--) begin
      if (chars[i] == CH_LPAREN) chars.push_back(CH_RPAREN);
      else if (chars[i] == CH_LBRACE) chars.push_back(CH_RBRACE);
      else chars.push_back(CH_RBRACK);
    end
    send_text(chars);
    chars = {};
    for (int i = 0; i <= NEST_DEPTH; i++) chars.push_back(opener_char(kind_t'($urandom_range(0, 2))));
    chars.push_back(CH_RPAREN);
    send_text(chars);

    run_phase(0, 0, 280);
    run_phase(64, 0, 290);
    run_phase(0, 64, 290);
    run_phase(35, 35, 290);

    stall_pct = 0;
    waited    = 0;
    while (pending != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    if (waited >= 10000) begin
      $display("FAIL bracket_balance_checker_unit");
      $finish;
    end else begin
      repeat (20) @(posedge clk);
      $display("sent %0d characters in %0d texts: %0d balanced, %0d unbalanced, %0d overflowed",
               items_sent, texts_balanced + texts_unbalanced + texts_overflowed,
               texts_balanced, texts_unbalanced, texts_overflowed);
      $display("compared %0d results, deepest nesting %0d, across four idle and stall mixes",
               results_seen, deepest_level);
      if (fail_count == 0) begin
        $display("PASS bracket_balance_checker_unit");
      end else begin
        $display("FAIL bracket_balance_checker_unit");
      end
      $finish;
    end
  end

endmodule

### files.f
+incdir+design
design/bbc_pkg.sv
design/bbc_in_if.sv
design/bbc_out_if.sv
design/bbc_step.sv
design/bbc_stack.sv
design/bracket_balance_checker_unit.sv
tb/bbc_checker.sv
tb/tb_top.sv
